@@ hw/rtl/sat_pkg.sv @@
`timescale 1ns / 1ps
// sat_pkg: band codes, fixed-point constants and shared types for the
// standard atmosphere pipeline; no dependencies
package sat_pkg;

	typedef logic [1:0] band_t;

	localparam band_t BAND_TROPO  = 2'd0;
	localparam band_t BAND_TPAUSE = 2'd1;
	localparam band_t BAND_STRAT1 = 2'd2;
	localparam band_t BAND_STRAT2 = 2'd3;

	typedef struct packed {
		logic  oor;
		band_t band;
	} sat_ctl_t;

	// altitude limits and band edges, feet
	localparam logic signed [18:0] ALT_LO   = -19'sd15000;
	localparam logic signed [18:0] ALT_HI   = 19'sd150000;
	localparam logic signed [18:0] H_TPAUSE = 19'sd36089;
	localparam logic signed [18:0] H_STRAT1 = 19'sd65617;
	localparam logic signed [18:0] H_STRAT2 = 19'sd104987;

	// lapse slopes in q50 per foot, tropopause slope in q44 per foot
	localparam logic [32:0] TH_C0 = 33'd7741214881;
	localparam logic [32:0] TH_C1 = 33'd1219864376;
	localparam logic [32:0] TH_C2 = 33'd1584006061;
	localparam logic [32:0] TH_C3 = 33'd4202443920;

	// rounding offsets with the fractional band base folded in
	localparam logic signed [31:0] TH_OFS0 = 32'sd524288;
	localparam logic signed [31:0] TH_OFS1 = -32'sd292243163;
	localparam logic signed [31:0] TH_OFS2 = 32'sd317325500;
	localparam logic signed [31:0] TH_OFS3 = 32'sd504817558;

	// tropopause exponent at the lower band edge
	localparam int Y_W = 28;
	localparam logic signed [Y_W-1:0] Y1_EDGE = 28'sd279;

	localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

	// base temperatures, centi-kelvin
	localparam logic [14:0] T0_TROPO = 15'd28815;
	localparam logic [14:0] T0_MID   = 15'd21665;
	localparam logic [14:0] T0_HIGH  = 15'd22865;

	// exponent magnitudes in q24 (band 0 positive, bands 2 and 3 negative)
	localparam logic [29:0] YC_0 = 30'd88179370;
	localparam logic [29:0] YC_2 = 30'd573166741;
	localparam logic [29:0] YC_3 = 30'd204702168;

	// base pressures, micro-psf
	localparam logic [31:0] PC_0 = 32'd2116220000;
	localparam logic [31:0] PC_1 = 32'd472678899;
	localparam logic [31:0] PC_2 = 32'd114344022;
	localparam logic [31:0] PC_3 = 32'd18128578;

	localparam logic [63:0] P_RND = 64'd83886080000;
	localparam logic [31:0] DIV_M = 32'd3518437209;

	// fahrenheit conversion, divide by ten via reciprocal
	localparam logic [21:0] F_OFS = 22'd459670;
	localparam logic [19:0] F_M   = 20'd838861;

	localparam int LOG_W = 25;
	localparam int EXP_W = 26;
	localparam int RAT_W = EXP_W + 5;

endpackage

@@ hw/rtl/standard_atmosphere_temp_pressure.sv @@
`timescale 1ns / 1ps
// standard_atmosphere_temp_pressure: altitude to standard-day temperature and
// pressure, sixteen stage pipeline; depends on sat_pkg
//
// channel   | direction | handshake           | payload
// ----------+-----------+---------------------+-------------------------------------
// command   | in        | start, busy         | altitude_ft
// result    | out       | done (one cycle)    | temp_kelvin_centi, temp_fahrenheit_centi,
//           |           |                     | pressure_psf_centi, out_of_range
//
// one transaction enters per clock; busy is never raised
// each result passes through the chain of pipelined
// multipliers (slope, interpolation, exponent, pressure, divide by ten thousand)
// reset clears only the stage valid bits; data registers run free
// the receiver cannot stall, so the pipeline never holds
module standard_atmosphere_temp_pressure #(
	parameter int TABLE_ADDR_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [18:0] altitude_ft,
	output logic               done,
	output logic [14:0]        temp_kelvin_centi,
	output logic signed [14:0] temp_fahrenheit_centi,
	output logic [18:0]        pressure_psf_centi,
	output logic               out_of_range
);
	import sat_pkg::*;

	localparam int TAB_N = (1 << TABLE_ADDR_BITS) + 1;
	localparam int IDX_W = TABLE_ADDR_BITS + 1;
	localparam int SH_L  = 30 - TABLE_ADDR_BITS;
	localparam int SH_E  = 24 - TABLE_ADDR_BITS;
	localparam int LAT   = 16;

	typedef logic [LOG_W-1:0] log_tab_t [TAB_N];
	typedef logic [EXP_W-1:0] exp_tab_t [TAB_N];

	// integer square root, bit by bit
	function automatic longint unsigned isqrt64(input longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		longint unsigned rm;
		r = 64'd0;
		b = 64'h4000_0000_0000_0000;
		rm = v;
		for (int j = 0; j < 32; j++) begin
			if (rm >= r + b) begin
				rm = rm - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// log2(1 + i/2^A) in q24, by repeated squaring
	function automatic log_tab_t gen_log_tab();
		log_tab_t t;
		longint unsigned x;
		longint unsigned ip;
		longint unsigned fr;
		for (int i = 0; i < TAB_N; i++) begin
			x = (64'd1 << 30) + (64'(i) << SH_L);
			ip = 64'd0;
			fr = 64'd0;
			if (x >= (64'd1 << 31)) begin
				ip = 64'd1;
				x = x >> 1;
			end
			for (int k = 0; k < 26; k++) begin
				x = (x * x + (64'd1 << 29)) >> 30;
				fr = fr << 1;
				if (x >= (64'd1 << 31)) begin
					fr = fr | 64'd1;
					x = x >> 1;
				end
			end
			t[i] = LOG_W'((ip << 24) + ((fr + 64'd2) >> 2));
		end
		return t;
	endfunction

	// 2^(i/2^A) in q24, product of repeated square roots of two
	function automatic exp_tab_t gen_exp_tab();
		exp_tab_t t;
		longint unsigned root [TABLE_ADDR_BITS+1];
		longint unsigned r;
		root[0] = 64'd1 << 31;
		for (int k = 1; k <= TABLE_ADDR_BITS; k++) begin
			root[k] = isqrt64(root[k-1] << 30);
		end
		for (int i = 0; i < TAB_N; i++) begin
			r = 64'd1 << 30;
			for (int k = 0; k <= TABLE_ADDR_BITS; k++) begin
				if (((i >> k) & 1) != 0) begin
					r = (r * root[TABLE_ADDR_BITS-k] + (64'd1 << 29)) >> 30;
				end
			end
			t[i] = EXP_W'((r + 64'd32) >> 6);
		end
		return t;
	endfunction

	localparam log_tab_t LOG_TAB = gen_log_tab();
	localparam exp_tab_t EXP_TAB = gen_exp_tab();

	// ---------------------------------------------------------------
	// stage valid bits and per-item control that rides along
	// ---------------------------------------------------------------
	logic [LAT:1] vld_q;
	sat_ctl_t     ctl_q [1:LAT];

	assign busy = 1'b0;
	assign done = vld_q[LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-1:1], start & ~busy};
		end
	end

	// ---------------------------------------------------------------
	// input decode: range check, band select, offset from band base
	// ---------------------------------------------------------------
	logic               oor_in;
	band_t              band_in;
	logic signed [18:0] k_in;
	logic [15:0]        kmag_in;

	always_comb begin
		oor_in = (altitude_ft < ALT_LO) || (altitude_ft > ALT_HI);
		if (altitude_ft < H_TPAUSE) begin
			band_in = BAND_TROPO;
			k_in = altitude_ft;
		end else if (altitude_ft < H_STRAT1) begin
			band_in = BAND_TPAUSE;
			k_in = altitude_ft - H_TPAUSE;
		end else if (altitude_ft < H_STRAT2) begin
			band_in = BAND_STRAT1;
			k_in = altitude_ft - H_STRAT1;
		end else begin
			band_in = BAND_STRAT2;
			k_in = altitude_ft - H_STRAT2;
		end
		kmag_in = k_in[18] ? 16'(-k_in) : k_in[15:0];
	end

	logic [15:0] kmag_s1;
	logic        kneg_s1, kzero_s1;

	always_ff @(posedge clk) begin
		ctl_q[1] <= '{oor: oor_in, band: band_in};
		kmag_s1 <= kmag_in;
		kneg_s1 <= k_in[18];
		kzero_s1 <= (kmag_in == 16'd0);
		for (int j = 2; j <= LAT; j++) begin
			ctl_q[j] <= ctl_q[j-1];
		end
	end

	// ---------------------------------------------------------------
	// s2: slope times offset
	// ---------------------------------------------------------------
	logic [32:0] th_c;
	logic [48:0] thprod_s2;
	logic        kneg_s2, kzero_s2;

	always_comb begin
		unique case (ctl_q[1].band)
			BAND_TROPO:  th_c = TH_C0;
			BAND_TPAUSE: th_c = TH_C1;
			BAND_STRAT1: th_c = TH_C2;
			BAND_STRAT2: th_c = TH_C3;
		endcase
	end

	always_ff @(posedge clk) begin
		thprod_s2 <= {16'b0, th_c} * {33'b0, kmag_s1};
		kneg_s2 <= kneg_s1;
		kzero_s2 <= kzero_s1;
	end

	// ---------------------------------------------------------------
	// s3: round to theta (q30), tropopause exponent directly
	// ---------------------------------------------------------------
	logic signed [31:0]    th_ofs;
	logic signed [50:0]    th_sum;
	logic [30:0]           th_rnd;
	logic [31:0]           th_calc;
	logic [30:0]           theta_s3;
	logic signed [Y_W-1:0] y1_s3;

	always_comb begin
		case (ctl_q[2].band)
			BAND_TROPO:  th_ofs = TH_OFS0;
			BAND_TPAUSE: th_ofs = TH_OFS1;
			BAND_STRAT1: th_ofs = TH_OFS2;
			default:     th_ofs = TH_OFS3;
		endcase
		th_sum = $signed({2'b00, thprod_s2}) + $signed({{19{th_ofs[31]}}, th_ofs});
		th_rnd = th_sum[50:20];
		case (ctl_q[2].band)
			BAND_TROPO:  th_calc = kneg_s2 ? ONE_Q30 + {1'b0, th_rnd}
			                               : ONE_Q30 - {1'b0, th_rnd};
			BAND_TPAUSE: th_calc = ONE_Q30;
			default:     th_calc = ONE_Q30 + {1'b0, th_rnd};
		endcase
	end

	always_ff @(posedge clk) begin
		theta_s3 <= th_calc[30:0];
		y1_s3 <= kzero_s2 ? Y1_EDGE : -$signed(Y_W'(th_rnd));
	end

	// ---------------------------------------------------------------
	// s4: normalize theta, log table read; theta times base temperature
	// ---------------------------------------------------------------
	logic [30:0]                 l_x;
	logic [IDX_W-1:0]            l_idx;
	logic [LOG_W-1:0]            l_lo, l_hi;
	logic [14:0]                 t0_sel;
	logic [LOG_W-1:0]            llo_s4, ldlt_s4;
	logic [SH_L-1:0]             lrem_s4;
	logic                        eneg_s4;
	logic [45:0]                 tprod_s4;
	logic signed [Y_W-1:0]       y1_s4;

	always_comb begin
		l_x = theta_s3[30] ? theta_s3 : {theta_s3[29:0], 1'b0};
		l_idx = {1'b0, l_x[29 -: TABLE_ADDR_BITS]};
		l_lo = LOG_TAB[l_idx];
		l_hi = LOG_TAB[l_idx + IDX_W'(1)];
		unique case (ctl_q[3].band)
			BAND_TROPO:  t0_sel = T0_TROPO;
			BAND_TPAUSE: t0_sel = T0_MID;
			BAND_STRAT1: t0_sel = T0_MID;
			BAND_STRAT2: t0_sel = T0_HIGH;
		endcase
	end

	always_ff @(posedge clk) begin
		llo_s4 <= l_lo;
		ldlt_s4 <= l_hi - l_lo;
		lrem_s4 <= l_x[SH_L-1:0];
		eneg_s4 <= ~theta_s3[30];
		tprod_s4 <= {31'b0, t0_sel} * {15'b0, theta_s3};
		y1_s4 <= y1_s3;
	end

	// ---------------------------------------------------------------
	// s5: log interpolation product; kelvin result
	// ---------------------------------------------------------------
	logic [LOG_W+SH_L-1:0] lprod_s5;
	logic [LOG_W-1:0]      llo_s5;
	logic                  eneg_s5;
	logic signed [Y_W-1:0] y1_s5;
	logic [46:0]           t_sum;
	logic [14:0]           tk_q [5:LAT-1];

	assign t_sum = {1'b0, tprod_s4} + (47'd1 << 29);

	always_ff @(posedge clk) begin
		lprod_s5 <= {{SH_L{1'b0}}, ldlt_s4} * {{LOG_W{1'b0}}, lrem_s4};
		llo_s5 <= llo_s4;
		eneg_s5 <= eneg_s4;
		y1_s5 <= y1_s4;
		tk_q[5] <= t_sum[44:30];
		for (int j = 6; j <= LAT-1; j++) begin
			tk_q[j] <= tk_q[j-1];
		end
	end

	// ---------------------------------------------------------------
	// s6: finish log2 as sign and magnitude; fahrenheit numerator
	// ---------------------------------------------------------------
	logic [LOG_W+SH_L:0]   l_rsum;
	logic [LOG_W-1:0]      l_v;
	logic [21:0]           f_num;
	logic [21:0]           f_abs;
	logic [LOG_W-1:0]      lmag_s6;
	logic                  lneg_s6;
	logic [19:0]           fmag_s6;
	logic                  fneg_s6;
	logic signed [Y_W-1:0] y1_s6;

	always_comb begin
		l_rsum = {1'b0, lprod_s5} + ((LOG_W+SH_L+1)'(1) << (SH_L - 1));
		l_v = llo_s5 + LOG_W'(l_rsum >> SH_L);
		f_num = ({7'b0, tk_q[5]} << 4) + ({7'b0, tk_q[5]} << 1) - F_OFS;
		f_abs = f_num[21] ? -f_num : f_num;
	end

	always_ff @(posedge clk) begin
		lmag_s6 <= eneg_s5 ? (LOG_W'(1) << 24) - l_v : l_v;
		lneg_s6 <= eneg_s5;
		fmag_s6 <= f_abs[19:0] + 20'd5;
		fneg_s6 <= f_num[21];
		y1_s6 <= y1_s5;
	end

	// ---------------------------------------------------------------
	// s7: exponent product; divide by ten product
	// ---------------------------------------------------------------
	logic [29:0]           yc_sel;
	logic                  yc_neg;
	logic [LOG_W+29:0]     ymag_s7;
	logic                  yneg_s7;
	logic [39:0]           fq_s7;
	logic                  fneg_s7;
	logic signed [Y_W-1:0] y1_s7;

	always_comb begin
		unique case (ctl_q[6].band)
			BAND_TROPO: begin
				yc_sel = YC_0;
				yc_neg = 1'b0;
			end
			BAND_TPAUSE: begin
				yc_sel = '0;
				yc_neg = 1'b0;
			end
			BAND_STRAT1: begin
				yc_sel = YC_2;
				yc_neg = 1'b1;
			end
			BAND_STRAT2: begin
				yc_sel = YC_3;
				yc_neg = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		ymag_s7 <= {30'b0, lmag_s6} * {{LOG_W{1'b0}}, yc_sel};
		yneg_s7 <= lneg_s6 ^ yc_neg;
		fq_s7 <= {20'b0, fmag_s6} * {20'b0, F_M};
		fneg_s7 <= fneg_s6;
		y1_s7 <= y1_s6;
	end

	// ---------------------------------------------------------------
	// s8: round exponent to q24; fahrenheit result
	// ---------------------------------------------------------------
	logic [LOG_W+30:0]     y_rsum;
	logic [Y_W-1:0]        y_q;
	logic [14:0]           f_q;
	logic signed [Y_W-1:0] y_s8;
	logic signed [14:0]    tf_q [8:LAT-1];

	always_comb begin
		y_rsum = {1'b0, ymag_s7} + ((LOG_W+31)'(1) << 23);
		y_q = Y_W'(y_rsum >> 24);
		f_q = fq_s7[37:23];
	end

	always_ff @(posedge clk) begin
		if (ctl_q[7].band == BAND_TPAUSE) begin
			y_s8 <= y1_s7;
		end else begin
			y_s8 <= yneg_s7 ? -$signed(y_q) : $signed(y_q);
		end
		tf_q[8] <= fneg_s7 ? -$signed(f_q) : $signed(f_q);
		for (int j = 9; j <= LAT-1; j++) begin
			tf_q[j] <= tf_q[j-1];
		end
	end

	// ---------------------------------------------------------------
	// s9: split exponent, exp table read
	// ---------------------------------------------------------------
	logic [IDX_W-1:0]    e_idx;
	logic [EXP_W-1:0]    e_lo, e_hi;
	logic [EXP_W-1:0]    elo_s9, edlt_s9;
	logic [SH_E-1:0]     erem_s9;
	logic signed [Y_W-25:0] n_s9;

	always_comb begin
		e_idx = {1'b0, y_s8[23 -: TABLE_ADDR_BITS]};
		e_lo = EXP_TAB[e_idx];
		e_hi = EXP_TAB[e_idx + IDX_W'(1)];
	end

	always_ff @(posedge clk) begin
		elo_s9 <= e_lo;
		edlt_s9 <= e_hi - e_lo;
		erem_s9 <= y_s8[SH_E-1:0];
		n_s9 <= y_s8[Y_W-1:24];
	end

	// ---------------------------------------------------------------
	// s10, s11: exp interpolation
	// ---------------------------------------------------------------
	logic [EXP_W+SH_E-1:0]  eprod_s10;
	logic [EXP_W-1:0]       elo_s10;
	logic signed [Y_W-25:0] n_s10;
	logic [EXP_W+SH_E:0]    e_rsum;
	logic [EXP_W-1:0]       ev_s11;
	logic signed [Y_W-25:0] n_s11;

	assign e_rsum = {1'b0, eprod_s10} + ((EXP_W+SH_E+1)'(1) << (SH_E - 1));

	always_ff @(posedge clk) begin
		eprod_s10 <= {{SH_E{1'b0}}, edlt_s9} * {{EXP_W{1'b0}}, erem_s9};
		elo_s10 <= elo_s9;
		n_s10 <= n_s9;
		ev_s11 <= elo_s10 + EXP_W'(e_rsum >> SH_E);
		n_s11 <= n_s10;
	end

	// ---------------------------------------------------------------
	// s12: scale by 2^n, capped upward, rounded downward
	// ---------------------------------------------------------------
	logic [Y_W-25:0]   n_mag;
	logic [2:0]        n_shl;
	logic [EXP_W:0]    r_sum;
	logic [RAT_W-1:0]  ratio_s12;

	always_comb begin
		n_mag = -n_s11;
		n_shl = (n_s11 > 4'sd5) ? 3'd5 : n_s11[2:0];
		r_sum = {1'b0, ev_s11} + ((EXP_W+1)'(1) << (n_mag - 4'd1));
	end

	always_ff @(posedge clk) begin
		if (n_s11 < 0) begin
			ratio_s12 <= RAT_W'(r_sum >> n_mag);
		end else begin
			ratio_s12 <= {5'b0, ev_s11} << n_shl;
		end
	end

	// ---------------------------------------------------------------
	// s13..s16: pressure, then divide by ten thousand via reciprocal
	// ---------------------------------------------------------------
	logic [31:0]          pc_sel;
	logic [RAT_W+31:0]    pprod_s13;
	logic [63:0]          p_sum;
	logic [31:0]          z_s14;
	logic [63:0]          zq_s15;
	logic [14:0]          tk_s16;
	logic signed [14:0]   tf_s16;
	logic [18:0]          p_s16;
	logic                 oor_s16;

	always_comb begin
		unique case (ctl_q[12].band)
			BAND_TROPO:  pc_sel = PC_0;
			BAND_TPAUSE: pc_sel = PC_1;
			BAND_STRAT1: pc_sel = PC_2;
			BAND_STRAT2: pc_sel = PC_3;
		endcase
		p_sum = {1'b0, pprod_s13} + P_RND;
	end

	always_ff @(posedge clk) begin
		pprod_s13 <= {{RAT_W{1'b0}}, pc_sel} * {32'b0, ratio_s12};
		z_s14 <= p_sum[55:24];
		zq_s15 <= {32'b0, z_s14} * {32'b0, DIV_M};
		// out-of-range items report all zero values
		oor_s16 <= ctl_q[15].oor;
		tk_s16 <= ctl_q[15].oor ? '0 : tk_q[LAT-1];
		tf_s16 <= ctl_q[15].oor ? '0 : tf_q[LAT-1];
		p_s16 <= ctl_q[15].oor ? '0 : zq_s15[63:45];
	end

	assign temp_kelvin_centi = tk_s16;
	assign temp_fahrenheit_centi = tf_s16;
	assign pressure_psf_centi = p_s16;
	assign out_of_range = oor_s16;

`ifndef NO_ASSERTIONS
	// fixed latency: every accepted transaction yields a result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("result missing after fixed latency");

	// range flag follows the altitude of the same transaction
	a_oor_match: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> out_of_range == $past(oor_in, LAT))
		else $error("range flag does not match its transaction");

	// out-of-range results carry zeros
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && out_of_range |-> temp_kelvin_centi == 15'd0
			&& temp_fahrenheit_centi == 15'sd0 && pressure_psf_centi == 19'd0)
		else $error("out-of-range result not zero");

	// in-range temperature is never zero kelvin
	a_temp_live: assert property (@(posedge clk) disable iff (!arst_n)
		done && !out_of_range |-> temp_kelvin_centi != 15'd0)
		else $error("in-range temperature is zero");
`endif

endmodule

@@ verif/standard_atmosphere_temp_pressure_tb.sv @@
`timescale 1ns / 1ps
// standard_atmosphere_temp_pressure_tb: self-checking bench for the standard atmosphere
// pipeline, with a fixed-point predictor kept in a small scoreboard class; depends on sat_pkg
module standard_atmosphere_temp_pressure_tb;
	import sat_pkg::*;

	localparam int TAB_BITS = 8;
	localparam int TAB_LEN  = (1 << TAB_BITS) + 1;
	localparam longint Q30  = 64'd1 << 30;
	localparam longint Q24  = 64'd1 << 24;
	localparam int QUIET_LIMIT = 5000;

	// expected contents of one result transaction
	typedef struct {
		logic [14:0]        kelvin;
		logic signed [14:0] fahrenheit;
		logic [18:0]        psf;
		logic               oor;
	} air_data_t;

	class atmo_scoreboard;
		longint log_rom[TAB_LEN];
		longint exp_rom[TAB_LEN];
		air_data_t pending[$];
		int errors;

		function new();
			longint unsigned root[TAB_BITS+1];
			longint unsigned x, ip, fr, r, v, b, rr;
			errors = 0;
			root[0] = 64'd1 << 31;
			for (int k = 1; k <= TAB_BITS; k++) begin
				// integer square root of root[k-1] in q30
				v = root[k-1] << 30;
				rr = 0;
				b = 64'd1 << 62;
				while (b > v) b = b >> 2;
				while (b != 0) begin
					if (v >= rr + b) begin
						v = v - (rr + b);
						rr = (rr >> 1) + b;
					end else begin
						rr = rr >> 1;
					end
					b = b >> 2;
				end
				root[k] = rr;
			end
			for (int i = 0; i < TAB_LEN; i++) begin
				x = Q30 + (longint'(i) << (30 - TAB_BITS));
				ip = 0;
				fr = 0;
				r = Q30;
				if (x >= (64'd1 << 31)) begin
					ip = 1;
					x = x >> 1;
				end
				// log2 by repeated squaring
				for (int k = 0; k < 26; k++) begin
					x = (x * x + (64'd1 << 29)) >> 30;
					fr = fr << 1;
					if (x >= (64'd1 << 31)) begin
						fr = fr | 1;
						x = x >> 1;
					end
				end
				log_rom[i] = (ip << 24) + ((fr + 2) >> 2);
				// exp2 by product of binary roots
				for (int k = 0; k <= TAB_BITS; k++)
					if ((i >> k) & 1)
						r = (r * root[TAB_BITS-k] + (64'd1 << 29)) >> 30;
				exp_rom[i] = (r + 32) >> 6;
			end
		endfunction

		// round to nearest, half away from zero; den positive
		function longint div_round(longint num, longint den);
			longint mag, q;
			mag = (num < 0) ? -num : num;
			q = (mag + den / 2) / den;
			return (num < 0) ? -q : q;
		endfunction

		function longint log2_fix(longint unsigned xin);
			longint e, idx, rem, lo, hi;
			longint unsigned x, frac;
			int sh;
			sh = 30 - TAB_BITS;
			x = xin;
			e = 0;
			if (x == 0) return -40 * Q24;
			while (x >= (64'd1 << 31)) begin
				x = x >> 1;
				e++;
			end
			while (x < Q30) begin
				x = x << 1;
				e--;
			end
			frac = x - Q30;
			idx = frac >> sh;
			rem = frac & ((64'd1 << sh) - 1);
			lo = log_rom[idx];
			hi = log_rom[idx+1];
			return e * Q24 + lo + (((hi - lo) * rem + (64'd1 << (sh - 1))) >>> sh);
		endfunction

		function longint unsigned exp2_fix(longint y);
			longint n, f, idx, rem, lo, hi;
			longint unsigned v;
			int sh;
			sh = 24 - TAB_BITS;
			if (y >= 0) n = y / Q24;
			else n = -((-y + 64'hFFFFFF) >> 24);
			f = y - n * Q24;
			idx = f >> sh;
			rem = f & ((64'd1 << sh) - 1);
			lo = exp_rom[idx];
			hi = exp_rom[idx+1];
			v = lo + (((hi - lo) * rem + (64'd1 << (sh - 1))) >>> sh);
			if (n >= 0) begin
				if (n > 5) n = 5;
				v = v << n;
			end else if (n < -40) begin
				v = 0;
			end else begin
				v = (v + (64'd1 << (-n - 1))) >> (-n);
			end
			return v;
		endfunction

		// note one accepted command and queue its expected result
		function void note_altitude(logic signed [18:0] alt);
			air_data_t res;
			longint h, theta, t0, y, tk, tf;
			longint unsigned pc, ratio, p;
			h = alt;
			res = '{kelvin: '0, fahrenheit: '0, psf: '0, oor: 1'b0};
			if (h < -15000 || h > 150000) begin
				res.oor = 1'b1;
			end else begin
				if (h < 36089) begin
					theta = Q30 - div_round(64'd7741214881 * h, 64'd1 << 20);
					t0 = 28815;
					pc = 64'd2116220000;
					y = div_round(64'd88179370 * log2_fix(theta), Q24);
				end else if (h < 65617) begin
					theta = Q30;
					t0 = 21665;
					pc = 64'd472678899;
					y = -div_round(64'd1219864376 * (100 * h - 3608924), 64'd100 << 20);
				end else if (h < 104987) begin
					theta = Q30 + div_round(64'd1584006061 * (100 * h - 6561680),
						64'd100 << 20);
					t0 = 21665;
					pc = 64'd114344022;
					y = div_round(-64'sd573166741 * log2_fix(theta), Q24);
				end else begin
					theta = Q30 + div_round(64'd4202443920 * (100 * h - 10498688),
						64'd100 << 20);
					t0 = 22865;
					pc = 64'd18128578;
					y = div_round(-64'sd204702168 * log2_fix(theta), Q24);
				end
				tk = div_round(t0 * theta, Q30);
				tf = div_round(18 * tk - 459670, 10);
				ratio = exp2_fix(y);
				p = (pc * ratio + ((64'd10000 << 24) / 2)) / (64'd10000 << 24);
				res.kelvin = tk[14:0];
				res.fahrenheit = tf[14:0];
				res.psf = p[18:0];
			end
			pending.push_back(res);
		endfunction

		function void check_result(logic [14:0] k, logic signed [14:0] f, logic [18:0] p,
				logic o);
			air_data_t exp_res;
			if (pending.size() == 0) begin
				$display("%0t: result with nothing pending: k=%0d f=%0d p=%0d oor=%0b",
					$time, k, f, p, o);
				errors++;
				return;
			end
			exp_res = pending.pop_front();
			if (k !== exp_res.kelvin) begin
				$display("%0t: kelvin expected %0d actual %0d", $time, exp_res.kelvin, k);
				errors++;
			end
			if (f !== exp_res.fahrenheit) begin
				$display("%0t: fahrenheit expected %0d actual %0d", $time,
					exp_res.fahrenheit, f);
				errors++;
			end
			if (p !== exp_res.psf) begin
				$display("%0t: pressure expected %0d actual %0d", $time, exp_res.psf, p);
				errors++;
			end
			if (o !== exp_res.oor) begin
				$display("%0t: out_of_range expected %0b actual %0b", $time, exp_res.oor, o);
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [18:0] altitude_ft;
	logic               done;
	logic [14:0]        temp_kelvin_centi;
	logic signed [14:0] temp_fahrenheit_centi;
	logic [18:0]        pressure_psf_centi;
	logic               out_of_range;

	atmo_scoreboard sb;
	int idle_pct;
	int quiet_cycles;

	standard_atmosphere_temp_pressure #(.TABLE_ADDR_BITS(TAB_BITS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.altitude_ft(altitude_ft),
		.done(done),
		.temp_kelvin_centi(temp_kelvin_centi),
		.temp_fahrenheit_centi(temp_fahrenheit_centi),
		.pressure_psf_centi(pressure_psf_centi),
		.out_of_range(out_of_range)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// monitor: commands and results are both taken at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_altitude(altitude_ft);
			if (done)
				sb.check_result(temp_kelvin_centi, temp_fahrenheit_centi,
					pressure_psf_centi, out_of_range);
		end
	end

	// watchdog: counts cycles in which no transaction moves either way
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// one command transaction, driven at the falling edge with random idle first
	task automatic send_altitude(input logic signed [18:0] alt);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			altitude_ft <= 19'($urandom);
			@(negedge clk);
		end
		start <= 1'b1;
		altitude_ft <= alt;
		while (busy) @(negedge clk);
		@(negedge clk);
	endtask

	// mostly in range, a share at band edges, a share on a span past both limits
	function automatic logic signed [18:0] pick_altitude();
		int sel, base;
		sel = $urandom_range(0, 99);
		if (sel < 65) return 19'(int'($urandom_range(0, 165000)) - 15000);
		if (sel < 85) begin
			case ($urandom_range(0, 5))
				0: base = -15000;
				1: base = 36089;
				2: base = 65617;
				3: base = 104987;
				4: base = 150000;
				default: base = 0;
			endcase
			return 19'(base + int'($urandom_range(0, 8)) - 4);
		end
		return 19'(int'($urandom_range(0, 196608)) - 32768);
	endfunction

	initial begin
		int edges[$];
		sb = new();
		quiet_cycles = 0;
		idle_pct = 0;
		arst_n = 1'b0;
		start = 1'b0;
		altitude_ft = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// limits, band edges on both sides, sea level and the field extremes
		edges = '{-32768, -15001, -15000, -14999, -1, 0, 1, 36088, 36089, 36090,
			65616, 65617, 65618, 104986, 104987, 104988, 149999, 150000, 150001,
			163840, -262144, 262143};
		foreach (edges[i]) send_altitude(19'(edges[i]));

		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 36 : (ph == 1) ? 87 : 0;
			repeat (580) send_altitude(pick_altitude());
		end
		start <= 1'b0;

		while (sb.pending.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (sb.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule

@@ files.f @@
hw/rtl/sat_pkg.sv
hw/rtl/standard_atmosphere_temp_pressure.sv
verif/standard_atmosphere_temp_pressure_tb.sv
